// ----- rtl/cc_cv_charge_controller_top_macros.svh -----
// Assertion macros for the charge controller top level.
`ifndef CC_CV_CHARGE_CONTROLLER_TOP_MACROS_SVH
`define CC_CV_CHARGE_CONTROLLER_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CCCV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger.
`define CCCV_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/cccv_pkg.sv -----
// Package: types, constants and codes shared by the charge controller files.
`default_nettype none
package cccv_pkg;

  localparam int unsigned WINDOW      = 10;
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned POS_W       = $clog2(WINDOW);
  localparam int unsigned SUM_W       = 14;
  localparam int unsigned AMP_W       = SAMPLE_BITS + 1;
  localparam int unsigned WIPER_W     = 8;
  localparam int unsigned PADDR_W     = 5;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  localparam logic [SUM_W-1:0]   ABSENT_RST  = 14'd2083;
  localparam logic [SUM_W-1:0]   DAMAGED_RST = 14'd6250;
  localparam logic [SUM_W-1:0]   CV_RST      = 14'd8542;
  localparam logic [SUM_W-1:0]   FULL_RST    = 14'd8750;
  localparam logic [WIPER_W-1:0] WIPER1_RST  = 8'd66;
  localparam logic [WIPER_W-1:0] WIPER2_RST  = 8'd149;
  localparam logic [WIPER_W-1:0] WIPER3_RST  = 8'd235;

  typedef enum logic [2:0] {
    REG_ABSENT  = 3'd0,
    REG_DAMAGED = 3'd1,
    REG_CV      = 3'd2,
    REG_FULL    = 3'd3,
    REG_WIPER1  = 3'd4,
    REG_WIPER2  = 3'd5,
    REG_WIPER3  = 3'd6,
    REG_NONE    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_CELL_KEY  = 2'd0,
    OP_START_KEY = 2'd1,
    OP_VOLTAGE   = 2'd2,
    OP_CURRENT   = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_MENU       = 4'd0,
    ST_STOP_FIRST = 4'd1,
    ST_SET_CELLS  = 4'd2,
    ST_ON         = 4'd3,
    ST_OFF        = 4'd4,
    ST_ABSENT     = 4'd5,
    ST_DAMAGED    = 4'd6,
    ST_CC         = 4'd7,
    ST_CV         = 4'd8,
    ST_CHARGED    = 4'd9,
    ST_CELLS_SET  = 4'd10
  } status_e;

  typedef struct packed {
    logic [SUM_W-1:0]   absent_thr;
    logic [SUM_W-1:0]   damaged_thr;
    logic [SUM_W-1:0]   cv_thr;
    logic [SUM_W-1:0]   full_thr;
    logic [WIPER_W-1:0] wiper1;
    logic [WIPER_W-1:0] wiper2;
    logic [WIPER_W-1:0] wiper3;
  } cfg_t;

  typedef struct packed {
    logic               [SUM_W-1:0]   current_sum;
    logic               [SUM_W-1:0]   voltage_sum;
    logic                             cv_select;
    logic                             charge_enable;
    logic               [WIPER_W-1:0] wiper_value;
    logic                             wiper_write;
    logic               [1:0]         cell_count;
    status_e                          status;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/cc_cv_charge_controller_top.sv -----
// Charge controller top level: command/sample stream in, status stream out.
//
// Input stream (s_axis): tuser carries the opcode (cell key, start/stop key,
// voltage sample, current sample), tdata carries the raw ADC sample in its
// low 10 bits. Every input beat produces exactly one output beat.
// Output stream (m_axis): status, cell count, wiper write strobe and value,
// relay drives and the two running sums of the last 10 samples.
// The beat is decoded against the current state and the result register
// loads at the accept edge. Throughput is one beat per cycle, set by the
// single result register with s_axis_tready held high whenever that
// register is empty or is being drained in the same cycle. If the receiver
// stalls, the result waits in the register and input is held off until it
// is taken; no beat is lost.
// Reset clears the rings, sums, cell count and charging state, opens the
// charge relay, selects the CV path and restores the default thresholds
// and wiper values. The APB port writes registers at byte address 4*i and
// must only be written while no result is outstanding.
`default_nettype none
`include "cc_cv_charge_controller_top_macros.svh"
module cc_cv_charge_controller_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [15:0]                  s_axis_tdata,  // [9:0] sample
  input  wire logic [1:0]                   s_axis_tuser,  // [1:0] opcode
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [3:0] status, [5:4] cell_count, [6] wiper_write, [14:7] wiper_value,
  // [15] charge_enable, [16] cv_select, [30:17] voltage_sum, [44:31] current_sum
  output logic      [47:0]                  m_axis_tdata,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cccv_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  localparam int unsigned SW = cccv_pkg::SAMPLE_BITS;
  localparam int unsigned AW = cccv_pkg::AMP_W;
  localparam int unsigned VW = cccv_pkg::SUM_W;
  localparam int unsigned PW = cccv_pkg::POS_W;

  cccv_pkg::cfg_t    cfg;
  cccv_pkg::result_t res_q, res_d;
  cccv_pkg::opcode_e op;

  logic              out_valid_q;
  logic              s_fire;
  logic [SW-1:0]     smp;
  logic signed [AW-1:0] amp_val;

  logic [1:0]        cells_q, cells_d;
  logic              chosen_q, chosen_d;
  logic              charging_q, charging_d;
  logic              relay_on_q, relay_on_d;
  logic              relay_cv_q, relay_cv_d;

  logic [SW-1:0]        volt_ring_q [cccv_pkg::WINDOW];
  logic signed [AW-1:0] amp_ring_q  [cccv_pkg::WINDOW];
  logic [PW-1:0]        volt_pos_q, amp_pos_q;
  logic [VW-1:0]        volt_total_q, volt_total_d;
  logic signed [VW-1:0] amp_total_q, amp_total_d;
  logic                 volt_push, amp_push;

  cccv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 48'(res_q);

  assign op        = cccv_pkg::opcode_e'(s_axis_tuser);
  assign smp       = s_axis_tdata[SW-1:0];
  assign amp_val   = $signed({1'b0, smp}) - $signed(AW'(1 << (SW - 1)));
  assign volt_push = s_fire && (op == cccv_pkg::OP_VOLTAGE);
  assign amp_push  = s_fire && (op == cccv_pkg::OP_CURRENT);

  assign volt_total_d = volt_total_q - VW'(volt_ring_q[volt_pos_q]) + VW'(smp);
  assign amp_total_d  = amp_total_q - VW'(amp_ring_q[amp_pos_q]) + VW'(amp_val);

  always_comb begin
    cells_d    = cells_q;
    chosen_d   = chosen_q;
    charging_d = charging_q;
    relay_on_d = relay_on_q;
    relay_cv_d = relay_cv_q;
    res_d             = res_q;
    res_d.status      = cccv_pkg::ST_MENU;
    res_d.wiper_write = 1'b0;
    res_d.voltage_sum = volt_total_q;
    res_d.current_sum = amp_total_q;
    case (op)
      cccv_pkg::OP_CELL_KEY: begin
        if (charging_q) begin
          res_d.status = cccv_pkg::ST_STOP_FIRST;
        end else begin
          cells_d           = (cells_q == 2'd3) ? 2'd1 : cells_q + 2'd1;
          chosen_d          = 1'b1;
          res_d.wiper_write = 1'b1;
          res_d.status      = cccv_pkg::ST_CELLS_SET;
        end
      end
      cccv_pkg::OP_START_KEY: begin
        if (charging_q) begin
          charging_d   = 1'b0;
          relay_on_d   = 1'b0;
          relay_cv_d   = 1'b1;
          res_d.status = cccv_pkg::ST_OFF;
        end else if (chosen_q) begin
          charging_d   = 1'b1;
          res_d.status = cccv_pkg::ST_ON;
        end else begin
          res_d.status = cccv_pkg::ST_SET_CELLS;
        end
      end
      cccv_pkg::OP_VOLTAGE: begin
        res_d.voltage_sum = volt_total_d;
        if (!charging_q) begin
          res_d.status = cccv_pkg::ST_MENU;
        end else if (volt_total_d <= cfg.absent_thr) begin
          relay_on_d   = 1'b0;
          res_d.status = cccv_pkg::ST_ABSENT;
        end else if (volt_total_d <= cfg.damaged_thr) begin
          relay_on_d   = 1'b0;
          res_d.status = cccv_pkg::ST_DAMAGED;
        end else if (volt_total_d < cfg.cv_thr) begin
          relay_on_d   = 1'b1;
          relay_cv_d   = 1'b0;
          res_d.status = cccv_pkg::ST_CC;
        end else if (volt_total_d < cfg.full_thr) begin
          relay_on_d   = 1'b1;
          relay_cv_d   = 1'b1;
          res_d.status = cccv_pkg::ST_CV;
        end else begin
          charging_d   = 1'b0;
          cells_d      = 2'd0;
          chosen_d     = 1'b0;
          relay_on_d   = 1'b0;
          res_d.status = cccv_pkg::ST_CHARGED;
        end
      end
      default: begin
        res_d.current_sum = amp_total_d;
        res_d.status      = charging_q ? cccv_pkg::ST_ON : cccv_pkg::ST_MENU;
      end
    endcase
    res_d.cell_count    = cells_d;
    res_d.charge_enable = relay_on_d;
    res_d.cv_select     = relay_cv_d;
    case (cells_d)
      2'd1:    res_d.wiper_value = cfg.wiper1;
      2'd2:    res_d.wiper_value = cfg.wiper2;
      2'd3:    res_d.wiper_value = cfg.wiper3;
      default: res_d.wiper_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cells_q     <= 2'd0;
      chosen_q    <= 1'b0;
      charging_q  <= 1'b0;
      relay_on_q  <= 1'b0;
      relay_cv_q  <= 1'b1;
    end else begin
      if (s_fire) begin
        out_valid_q <= 1'b1;
        cells_q     <= cells_d;
        chosen_q    <= chosen_d;
        charging_q  <= charging_d;
        relay_on_q  <= relay_on_d;
        relay_cv_q  <= relay_cv_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cccv_pkg::WINDOW; i++) begin
        volt_ring_q[i] <= '0;
        amp_ring_q[i]  <= '0;
      end
      volt_pos_q   <= '0;
      amp_pos_q    <= '0;
      volt_total_q <= '0;
      amp_total_q  <= '0;
    end else begin
      if (volt_push) begin
        volt_ring_q[volt_pos_q] <= smp;
        volt_pos_q   <= (volt_pos_q == cccv_pkg::POS_LAST) ? '0 : volt_pos_q + PW'(1);
        volt_total_q <= volt_total_d;
      end
      if (amp_push) begin
        amp_ring_q[amp_pos_q] <= amp_val;
        amp_pos_q   <= (amp_pos_q == cccv_pkg::POS_LAST) ? '0 : amp_pos_q + PW'(1);
        amp_total_q <= amp_total_d;
      end
    end
  end

  `CCCV_ASSERT(a_chosen_matches_cells, chosen_q == (cells_q != 2'd0), "cell flag out of sync")
  `CCCV_ASSERT(a_charging_needs_cells, !charging_q || chosen_q, "charging without cells")
  `CCCV_ASSERT_NEXT(a_beat_gives_result, s_fire, m_axis_tvalid, "accepted beat lost")
  `CCCV_ASSERT_NEXT(a_relay_off_when_idle, s_fire && !charging_d, !relay_on_q, "relay on while idle")

endmodule
`default_nettype wire

// ----- rtl/cccv_regs.sv -----
// APB configuration register file for the charge controller.
`default_nettype none
module cccv_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cccv_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output cccv_pkg::cfg_t                     cfg_o
);

  cccv_pkg::cfg_t   cfg_q, cfg_d;
  cccv_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = cccv_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        cccv_pkg::REG_ABSENT:  cfg_d.absent_thr  = pwdata[cccv_pkg::SUM_W-1:0];
        cccv_pkg::REG_DAMAGED: cfg_d.damaged_thr = pwdata[cccv_pkg::SUM_W-1:0];
        cccv_pkg::REG_CV:      cfg_d.cv_thr      = pwdata[cccv_pkg::SUM_W-1:0];
        cccv_pkg::REG_FULL:    cfg_d.full_thr    = pwdata[cccv_pkg::SUM_W-1:0];
        cccv_pkg::REG_WIPER1:  cfg_d.wiper1      = pwdata[cccv_pkg::WIPER_W-1:0];
        cccv_pkg::REG_WIPER2:  cfg_d.wiper2      = pwdata[cccv_pkg::WIPER_W-1:0];
        cccv_pkg::REG_WIPER3:  cfg_d.wiper3      = pwdata[cccv_pkg::WIPER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cccv_pkg::REG_ABSENT:  prdata = 32'(cfg_q.absent_thr);
      cccv_pkg::REG_DAMAGED: prdata = 32'(cfg_q.damaged_thr);
      cccv_pkg::REG_CV:      prdata = 32'(cfg_q.cv_thr);
      cccv_pkg::REG_FULL:    prdata = 32'(cfg_q.full_thr);
      cccv_pkg::REG_WIPER1:  prdata = 32'(cfg_q.wiper1);
      cccv_pkg::REG_WIPER2:  prdata = 32'(cfg_q.wiper2);
      cccv_pkg::REG_WIPER3:  prdata = 32'(cfg_q.wiper3);
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.absent_thr  <= cccv_pkg::ABSENT_RST;
      cfg_q.damaged_thr <= cccv_pkg::DAMAGED_RST;
      cfg_q.cv_thr      <= cccv_pkg::CV_RST;
      cfg_q.full_thr    <= cccv_pkg::FULL_RST;
      cfg_q.wiper1      <= cccv_pkg::WIPER1_RST;
      cfg_q.wiper2      <= cccv_pkg::WIPER2_RST;
      cfg_q.wiper3      <= cccv_pkg::WIPER3_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire
